// ===== design/ntcs_pkg.sv =====
// Shared types and constants for the nearest triangle centroid search unit.
// No dependencies; imported by every module of the block.
package ntcs_pkg;

   // Table geometry fixed by the 10-bit slot and corner fields
   localparam int SLOT_W        = 10;
   localparam int CORNER_W      = 10;
   localparam int TRI_W         = 3 * CORNER_W;
   localparam int COUNT_W       = 11;
   localparam int MAX_VERTICES  = 1024;
   localparam int MAX_TRIANGLES = 1024;

   // Transaction opcodes
   localparam logic [1:0] OP_WRITE_VERTEX   = 2'd0;
   localparam logic [1:0] OP_WRITE_TRIANGLE = 2'd1;
   localparam logic [1:0] OP_QUERY          = 2'd2;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_TRI,
      ST_VA,
      ST_VB,
      ST_VC,
      ST_SUM,
      ST_DIFF,
      ST_SQX,
      ST_SQY,
      ST_SQZ,
      ST_CMP,
      ST_DONE
   } state_type;

   // Axis fed to the shared squaring multiplier
   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   // Sequencer controls for the distance datapath
   typedef struct packed {
      logic     query_load;
      logic     sum_load;
      logic     sum_add;
      logic     diff_en;
      logic     sq_en;
      axis_type sq_axis;
      logic     acc_load;
      logic     acc_add;
   } dist_ctrl_type;

endpackage

// ===== design/nearest_triangle_centroid_search_unit.sv =====
// A query walks each searched triangle through the sequencer states TRI, VA, VB,
// VC, SUM, DIFF, SQX, SQY, SQZ and CMP, then goes to DONE; with no triangles to
// search it goes straight to DONE. The next transaction is taken once the result
// is registered. The per-triangle walk is set by the one vertex read port (three
// corner reads) and the one squaring multiplier shared by X, Y and Z. Reset clears
// the sequencer, count and response valid; the vertex and triangle tables are undefined until written and not cleared.
module nearest_triangle_centroid_search_unit #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_opcode,
   input  logic [ntcs_pkg::SLOT_W-1:0]        req_slot,
   input  logic signed [COORD_WIDTH-1:0]      req_coord_x,
   input  logic signed [COORD_WIDTH-1:0]      req_coord_y,
   input  logic signed [COORD_WIDTH-1:0]      req_coord_z,
   input  logic [ntcs_pkg::CORNER_W-1:0]      req_corner_a,
   input  logic [ntcs_pkg::CORNER_W-1:0]      req_corner_b,
   input  logic [ntcs_pkg::CORNER_W-1:0]      req_corner_c,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_found,
   output logic [ntcs_pkg::SLOT_W-1:0]        rsp_triangle_index,
   input  logic                               csr_wr_en,
   input  logic [ntcs_pkg::COUNT_W-1:0]       csr_wr_data
);
   import ntcs_pkg::*;

   localparam int DIST_W = 2 * (COORD_WIDTH + 2) + 2;
   localparam int VTX_W  = 3 * COORD_WIDTH;

   state_type            state_ff, state_in;
   dist_ctrl_type        ctrl;
   logic [COUNT_W-1:0]   count_ff;
   logic [COUNT_W-1:0]   count_lim;
   logic [COUNT_W-1:0]   tri_idx_ff;
   logic [COUNT_W-1:0]   tri_next;
   logic                 tri_last;
   logic [TRI_W-1:0]     tri_rd_ff;
   logic [VTX_W-1:0]     vtx_rd_ff;
   logic [CORNER_W-1:0]  vtx_addr;
   logic                 vtx_rd_en;
   logic                 tri_rd_en;
   logic                 cmp_en;
   logic                 done_load;
   logic                 req_accept;
   logic                 query_accept;
   logic [DIST_W-1:0]    sq_dist;
   logic [DIST_W-1:0]    best_dist_ff;
   logic                 best_valid_ff;
   logic [SLOT_W-1:0]    best_idx_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_found_ff;
   logic [SLOT_W-1:0]    rsp_index_ff;

   logic [VTX_W-1:0]     vtx_mem [MAX_VERTICES];
   logic [TRI_W-1:0]     tri_mem [MAX_TRIANGLES];

   assign req_accept   = req_valid && req_ready;
   assign query_accept = req_accept && (req_opcode == OP_QUERY);

   // Counts above the table depth search the whole table
   assign count_lim = (count_ff > COUNT_W'(MAX_TRIANGLES)) ? COUNT_W'(MAX_TRIANGLES)
                                                          : count_ff;
   assign tri_next  = tri_idx_ff + 1'b1;
   assign tri_last  = (tri_next == count_lim);

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (query_accept) begin
               state_in = (count_lim == '0) ? ST_DONE : ST_TRI;
            end
         end
         ST_TRI:  state_in = ST_VA;
         ST_VA:   state_in = ST_VB;
         ST_VB:   state_in = ST_VC;
         ST_VC:   state_in = ST_SUM;
         ST_SUM:  state_in = ST_DIFF;
         ST_DIFF: state_in = ST_SQX;
         ST_SQX:  state_in = ST_SQY;
         ST_SQY:  state_in = ST_SQZ;
         ST_SQZ:  state_in = ST_CMP;
         ST_CMP:  state_in = tri_last ? ST_DONE : ST_TRI;
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ready = 1'b0;
      ctrl      = '0;
      ctrl.sq_axis = AXIS_X;
      tri_rd_en = 1'b0;
      vtx_rd_en = 1'b0;
      vtx_addr  = tri_rd_ff[CORNER_W-1:0];
      cmp_en    = 1'b0;
      done_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready       = 1'b1;
            ctrl.query_load = query_accept;
         end
         ST_TRI: tri_rd_en = 1'b1;
         ST_VA: begin
            vtx_rd_en = 1'b1;
            vtx_addr  = tri_rd_ff[CORNER_W-1:0];
         end
         ST_VB: begin
            vtx_rd_en     = 1'b1;
            vtx_addr      = tri_rd_ff[2*CORNER_W-1:CORNER_W];
            ctrl.sum_load = 1'b1;
         end
         ST_VC: begin
            vtx_rd_en    = 1'b1;
            vtx_addr     = tri_rd_ff[3*CORNER_W-1:2*CORNER_W];
            ctrl.sum_add = 1'b1;
         end
         ST_SUM:  ctrl.sum_add = 1'b1;
         ST_DIFF: ctrl.diff_en = 1'b1;
         ST_SQX: begin
            ctrl.sq_en   = 1'b1;
            ctrl.sq_axis = AXIS_X;
         end
         ST_SQY: begin
            ctrl.sq_en    = 1'b1;
            ctrl.sq_axis  = AXIS_Y;
            ctrl.acc_load = 1'b1;
         end
         ST_SQZ: begin
            ctrl.sq_en   = 1'b1;
            ctrl.sq_axis = AXIS_Z;
            ctrl.acc_add = 1'b1;
         end
         ST_CMP:  cmp_en = 1'b1;
         ST_DONE: done_load = !rsp_valid_ff || rsp_ready;
         default: ;
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         best_valid_ff <= 1'b0;
         tri_idx_ff    <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            count_ff <= csr_wr_data;
         end
         if (done_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (query_accept) begin
            best_valid_ff <= 1'b0;
            tri_idx_ff    <= '0;
         end else if (cmp_en) begin
            tri_idx_ff <= tri_next;
            if (!best_valid_ff || (sq_dist < best_dist_ff)) begin
               best_valid_ff <= 1'b1;
            end
         end
      end
   end

   // Best candidate and response payload
   always_ff @(posedge clock) begin
      if (cmp_en && (!best_valid_ff || (sq_dist < best_dist_ff))) begin
         best_dist_ff <= sq_dist;
         best_idx_ff  <= tri_idx_ff[SLOT_W-1:0];
      end
      if (done_load) begin
         rsp_found_ff <= best_valid_ff;
         rsp_index_ff <= best_valid_ff ? best_idx_ff : '0;
      end
   end

   // Vertex table: written on a vertex transaction, read one corner a cycle
   always_ff @(posedge clock) begin
      if (req_accept && (req_opcode == OP_WRITE_VERTEX)) begin
         vtx_mem[req_slot] <= {req_coord_z, req_coord_y, req_coord_x};
      end
      if (vtx_rd_en) begin
         vtx_rd_ff <= vtx_mem[vtx_addr];
      end
   end

   // Triangle table: written on a triangle transaction, read once per triangle
   always_ff @(posedge clock) begin
      if (req_accept && (req_opcode == OP_WRITE_TRIANGLE)) begin
         tri_mem[req_slot] <= {req_corner_c, req_corner_b, req_corner_a};
      end
      if (tri_rd_en) begin
         tri_rd_ff <= tri_mem[tri_idx_ff[SLOT_W-1:0]];
      end
   end

   ntcs_dist #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_dist (
      .clock    (clock),
      .ctrl     (ctrl),
      .query_x  (req_coord_x),
      .query_y  (req_coord_y),
      .query_z  (req_coord_z),
      .vertex_x (vtx_rd_ff[COORD_WIDTH-1:0]),
      .vertex_y (vtx_rd_ff[2*COORD_WIDTH-1:COORD_WIDTH]),
      .vertex_z (vtx_rd_ff[3*COORD_WIDTH-1:2*COORD_WIDTH]),
      .sq_dist  (sq_dist)
   );

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_found          = rsp_found_ff;
   assign rsp_triangle_index = rsp_index_ff;

endmodule

// ===== design/ntcs_dist.sv =====
// Distance datapath: corner sums, |3p - (A+B+C)| per axis, one shared squarer
// and the squared-distance accumulator. Depends on ntcs_pkg.
module ntcs_dist #(
   parameter int COORD_WIDTH = 24
) (
   input  logic                                clock,
   input  ntcs_pkg::dist_ctrl_type             ctrl,
   input  logic signed [COORD_WIDTH-1:0]       query_x,
   input  logic signed [COORD_WIDTH-1:0]       query_y,
   input  logic signed [COORD_WIDTH-1:0]       query_z,
   input  logic signed [COORD_WIDTH-1:0]       vertex_x,
   input  logic signed [COORD_WIDTH-1:0]       vertex_y,
   input  logic signed [COORD_WIDTH-1:0]       vertex_z,
   output logic [2*(COORD_WIDTH+2)+1:0]        sq_dist
);
   import ntcs_pkg::*;

   localparam int SUM_W  = COORD_WIDTH + 2;
   localparam int DIFF_W = COORD_WIDTH + 3;
   localparam int MAG_W  = COORD_WIDTH + 2;
   localparam int SQ_W   = 2 * MAG_W;
   localparam int DIST_W = SQ_W + 2;

   logic signed [COORD_WIDTH-1:0] query_lane  [3];
   logic signed [COORD_WIDTH-1:0] vertex_lane [3];
   logic signed [SUM_W-1:0]       p3_ff  [3];
   logic signed [SUM_W-1:0]       sum_ff [3];
   logic [MAG_W-1:0]              mag_ff [3];
   logic [SQ_W-1:0]               prod_ff;
   logic [DIST_W-1:0]             acc_ff;
   logic [MAG_W-1:0]              mag_sel;
   logic [SQ_W-1:0]               square;

   assign query_lane[0]  = query_x;
   assign query_lane[1]  = query_y;
   assign query_lane[2]  = query_z;
   assign vertex_lane[0] = vertex_x;
   assign vertex_lane[1] = vertex_y;
   assign vertex_lane[2] = vertex_z;

   // Per-axis lanes: 3p, corner sum, and magnitude of the difference
   for (genvar i = 0; i < 3; i++) begin : g_lane
      logic signed [SUM_W-1:0]  query_ext;
      logic signed [SUM_W-1:0]  vertex_ext;
      logic signed [DIFF_W-1:0] diff;
      logic [DIFF_W-1:0]        diff_abs;

      assign query_ext  = SUM_W'(query_lane[i]);
      assign vertex_ext = SUM_W'(vertex_lane[i]);
      assign diff       = DIFF_W'(p3_ff[i]) - DIFF_W'(sum_ff[i]);
      assign diff_abs   = diff[DIFF_W-1] ? (~diff + 1'b1) : diff;

      always_ff @(posedge clock) begin
         if (ctrl.query_load) begin
            p3_ff[i] <= (query_ext <<< 1) + query_ext;
         end
         if (ctrl.sum_load) begin
            sum_ff[i] <= vertex_ext;
         end else if (ctrl.sum_add) begin
            sum_ff[i] <= sum_ff[i] + vertex_ext;
         end
         if (ctrl.diff_en) begin
            mag_ff[i] <= diff_abs[MAG_W-1:0];
         end
      end
   end

   // Shared squarer input select
   always_comb begin
      unique case (ctrl.sq_axis)
         AXIS_X:  mag_sel = mag_ff[0];
         AXIS_Y:  mag_sel = mag_ff[1];
         AXIS_Z:  mag_sel = mag_ff[2];
         default: mag_sel = mag_ff[0];
      endcase
   end

   assign square = mag_sel * mag_sel;

   // Product register and running sum of squares
   always_ff @(posedge clock) begin
      if (ctrl.sq_en) begin
         prod_ff <= square;
      end
      if (ctrl.acc_load) begin
         acc_ff <= DIST_W'(prod_ff);
      end else if (ctrl.acc_add) begin
         acc_ff <= acc_ff + DIST_W'(prod_ff);
      end
   end

   // Final term folds in on the compare cycle
   assign sq_dist = acc_ff + DIST_W'(prod_ff);

endmodule

// ===== design/ntcs_checker.sv =====
// Port-level checks for the nearest triangle centroid search unit, bound to
// the top level. Depends on ntcs_pkg.
module ntcs_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        req_valid,
   input logic                        req_ready,
   input logic [1:0]                  req_opcode,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic                        rsp_found,
   input logic [ntcs_pkg::SLOT_W-1:0] rsp_triangle_index
);
   import ntcs_pkg::*;

   // An empty search reports index zero
   a_not_found_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_found) |-> (rsp_triangle_index == '0))
      else $error("not-found response carries a nonzero triangle index");

   // A query transaction occupies the block
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_opcode == OP_QUERY)) |=> !req_ready)
      else $error("request taken in the cycle after a query");

   // A response only appears after a busy period
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("response raised without a preceding search");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_found) && $stable(rsp_triangle_index)))
      else $error("stalled response changed or dropped");

endmodule

bind nearest_triangle_centroid_search_unit ntcs_checker u_ntcs_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .req_opcode         (req_opcode),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_found          (rsp_found),
   .rsp_triangle_index (rsp_triangle_index)
);

// ===== sim/tb.sv =====
// Self-checking testbench for nearest_triangle_centroid_search_unit: loads the
// vertex and triangle tables, sweeps the triangle count and checks every query answer.
// Depends on ntcs_pkg and the unit's RTL only.
module tb;
   import ntcs_pkg::*;

   localparam int COORD_W       = 24;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int SETTLE_CYCLES = 8;
   localparam int HOLD_CYCLES   = 300;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic signed [COORD_W-1:0] COORD_MAX = 24'sh7FFFFF;
   localparam logic signed [COORD_W-1:0] COORD_MIN = 24'sh800000;

   typedef struct {
      logic [1:0]                opcode;
      logic [SLOT_W-1:0]         slot;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [COORD_W-1:0] z;
      logic [CORNER_W-1:0]       a;
      logic [CORNER_W-1:0]       b;
      logic [CORNER_W-1:0]       c;
   } unit_request_type;

   typedef struct packed {
      logic [CORNER_W-1:0] c;
      logic [CORNER_W-1:0] b;
      logic [CORNER_W-1:0] a;
   } facet_corners_type;

   typedef struct {
      logic              found;
      logic [SLOT_W-1:0] index;
   } nearest_result_type;

   // DUT connections
   logic                      clock;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_opcode = '0;
   logic [SLOT_W-1:0]         req_slot = '0;
   logic signed [COORD_W-1:0] req_coord_x = '0;
   logic signed [COORD_W-1:0] req_coord_y = '0;
   logic signed [COORD_W-1:0] req_coord_z = '0;
   logic [CORNER_W-1:0]       req_corner_a = '0;
   logic [CORNER_W-1:0]       req_corner_b = '0;
   logic [CORNER_W-1:0]       req_corner_c = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic                      rsp_found;
   logic [SLOT_W-1:0]         rsp_triangle_index;
   logic                      csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]        csr_wr_data = '0;

   // Shadow copy of the unit's tables and count register
   logic signed [COORD_W-1:0] shadow_vx [MAX_VERTICES];
   logic signed [COORD_W-1:0] shadow_vy [MAX_VERTICES];
   logic signed [COORD_W-1:0] shadow_vz [MAX_VERTICES];
   facet_corners_type         shadow_facets [MAX_TRIANGLES];
   logic [COUNT_W-1:0]        model_count = '0;

   // Stimulus bookkeeping: which entries the queued transactions will have written
   bit                vtx_written [MAX_VERTICES];
   int                vtx_slots [$];
   bit                facet_written [MAX_TRIANGLES];
   facet_corners_type facet_plan [MAX_TRIANGLES];

   unit_request_type   requests_to_send [$];
   nearest_result_type answers_due [$];
   unit_request_type   req_cur;
   int                 req_gap = 0;
   int                 rsp_wait = 0;
   int                 queued_total = 0;
   int                 accepted_total = 0;
   int                 results_seen = 0;
   int                 error_count = 0;
   int                 cycle_count = 0;
   bit                 calm_phase = 1'b0;

   nearest_triangle_centroid_search_unit #(
      .COORD_WIDTH(COORD_W)
   ) u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_opcode         (req_opcode),
      .req_slot           (req_slot),
      .req_coord_x        (req_coord_x),
      .req_coord_y        (req_coord_y),
      .req_coord_z        (req_coord_z),
      .req_corner_a       (req_corner_a),
      .req_corner_b       (req_corner_b),
      .req_corner_c       (req_corner_c),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_found          (rsp_found),
      .rsp_triangle_index (rsp_triangle_index),
      .csr_wr_en          (csr_wr_en),
      .csr_wr_data        (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb: FAIL");
         $finish;
      end
   end

   function automatic int searched_count();
      return (model_count > MAX_TRIANGLES) ? MAX_TRIANGLES : int'(model_count);
   endfunction

   function automatic int pick_gap();
      return calm_phase ? 0 : $urandom_range(0, 4);
   endfunction

   // Squared distance along one axis, with the gap scaled by 3 to avoid the divide
   function automatic longint axis_gap_sq(logic signed [COORD_W-1:0] q,
                                          logic signed [COORD_W-1:0] u,
                                          logic signed [COORD_W-1:0] v,
                                          logic signed [COORD_W-1:0] w);
      longint d;
      d = 3 * longint'(q) - (longint'(u) + longint'(v) + longint'(w));
      return d * d;
   endfunction

   // Linear search over the triangles in use; strict less-than keeps the first tie
   function automatic nearest_result_type nearest_centroid(logic signed [COORD_W-1:0] px,
                                                           logic signed [COORD_W-1:0] py,
                                                           logic signed [COORD_W-1:0] pz);
      nearest_result_type res;
      facet_corners_type  f;
      longint             cand_dist;
      longint             best_dist;
      bit                 have_best;
      res.found = 1'b0;
      res.index = '0;
      have_best = 1'b0;
      best_dist = 0;
      for (int t = 0; t < searched_count(); t++) begin
         f = shadow_facets[t];
         cand_dist = axis_gap_sq(px, shadow_vx[f.a], shadow_vx[f.b], shadow_vx[f.c])
                   + axis_gap_sq(py, shadow_vy[f.a], shadow_vy[f.b], shadow_vy[f.c])
                   + axis_gap_sq(pz, shadow_vz[f.a], shadow_vz[f.b], shadow_vz[f.c]);
         if (!have_best || cand_dist < best_dist) begin
            have_best = 1'b1;
            best_dist = cand_dist;
            res.found = 1'b1;
            res.index = t[SLOT_W-1:0];
         end
      end
      return res;
   endfunction

   // Accepted transaction: update the shadow tables or predict the answer
   function automatic void absorb_request(unit_request_type r);
      case (r.opcode)
         OP_WRITE_VERTEX: begin
            shadow_vx[r.slot] = r.x;
            shadow_vy[r.slot] = r.y;
            shadow_vz[r.slot] = r.z;
         end
         OP_WRITE_TRIANGLE: begin
            shadow_facets[r.slot] = {r.c, r.b, r.a};
         end
         OP_QUERY: begin
            answers_due.insert(answers_due.size(), nearest_centroid(r.x, r.y, r.z));
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("tb: mismatch, %s: got %0d, expected %0d (response %0d)",
               what, got, want, results_seen);
      error_count++;
   endtask

   // Request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            absorb_request(req_cur);
            accepted_total++;
         end
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_valid <= 1'b0;
               req_gap   <= req_gap - 1;
            end else if (requests_to_send.size() > 0) begin
               req_cur = requests_to_send.pop_front();
               req_valid    <= 1'b1;
               req_opcode   <= req_cur.opcode;
               req_slot     <= req_cur.slot;
               req_coord_x  <= req_cur.x;
               req_coord_y  <= req_cur.y;
               req_coord_z  <= req_cur.z;
               req_corner_a <= req_cur.a;
               req_corner_b <= req_cur.b;
               req_corner_c <= req_cur.c;
               req_gap      <= pick_gap();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor; two long hold-offs back the unit up into its input
   always @(posedge clock) begin : rsp_side
      int next_wait;
      nearest_result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_wait  <= 0;
      end else begin
         next_wait = rsp_wait;
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (answers_due.size() == 0) begin
               report_mismatch("response with no query waiting",
                               int'(rsp_triangle_index), -1);
            end else begin
               want = answers_due.pop_front();
               if (rsp_found !== want.found)
                  report_mismatch("found", int'(rsp_found), int'(want.found));
               if (rsp_triangle_index !== want.index)
                  report_mismatch("triangle_index", int'(rsp_triangle_index),
                                  int'(want.index));
            end
            next_wait = (results_seen == 20 || results_seen == 120) ? HOLD_CYCLES : pick_gap();
         end
         if (next_wait > 0) begin
            rsp_ready <= 1'b0;
            rsp_wait  <= next_wait - 1;
         end else begin
            rsp_ready <= 1'b1;
            rsp_wait  <= 0;
         end
      end
   end

   // ---- stimulus helpers ----

   function automatic unit_request_type noise_request(logic [1:0] op);
      unit_request_type r;
      r.opcode = op;
      r.slot   = SLOT_W'($urandom());
      r.x      = COORD_W'($urandom());
      r.y      = COORD_W'($urandom());
      r.z      = COORD_W'($urandom());
      r.a      = CORNER_W'($urandom());
      r.b      = CORNER_W'($urandom());
      r.c      = CORNER_W'($urandom());
      return r;
   endfunction

   function automatic logic signed [COORD_W-1:0] rand_coord();
      int pick;
      pick = $urandom_range(0, 9);
      if (pick == 0) return COORD_MAX;
      if (pick == 1) return COORD_MIN;
      if (pick < 4) return COORD_W'($urandom_range(0, 16) - 8);
      if (pick < 6) return COORD_W'($urandom_range(0, 8191) - 4096);
      return COORD_W'($urandom());
   endfunction

   // Corners only ever point at vertices that are already written
   function automatic logic [CORNER_W-1:0] rand_corner();
      return CORNER_W'(vtx_slots[$urandom_range(0, vtx_slots.size() - 1)]);
   endfunction

   task automatic queue_request(unit_request_type r);
      requests_to_send.insert(requests_to_send.size(), r);
      queued_total++;
   endtask

   task automatic add_vertex(int slot, logic signed [COORD_W-1:0] x,
                             logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z);
      unit_request_type r;
      r = noise_request(OP_WRITE_VERTEX);
      r.slot = SLOT_W'(slot);
      r.x = x;
      r.y = y;
      r.z = z;
      queue_request(r);
      if (!vtx_written[slot]) begin
         vtx_written[slot] = 1'b1;
         vtx_slots.insert(vtx_slots.size(), slot);
      end
   endtask

   task automatic add_facet(int slot, logic [CORNER_W-1:0] a, logic [CORNER_W-1:0] b,
                            logic [CORNER_W-1:0] c);
      unit_request_type r;
      r = noise_request(OP_WRITE_TRIANGLE);
      r.slot = SLOT_W'(slot);
      r.a = a;
      r.b = b;
      r.c = c;
      queue_request(r);
      facet_written[slot] = 1'b1;
      facet_plan[slot] = {c, b, a};
   endtask

   task automatic add_query(logic signed [COORD_W-1:0] x, logic signed [COORD_W-1:0] y,
                            logic signed [COORD_W-1:0] z);
      unit_request_type r;
      // every searched triangle must be written first
      for (int t = 0; t < searched_count(); t++)
         if (!facet_written[t]) add_facet(t, rand_corner(), rand_corner(), rand_corner());
      r = noise_request(OP_QUERY);
      r.x = x;
      r.y = y;
      r.z = z;
      queue_request(r);
   endtask

   task automatic add_random_item();
      int pick;
      int n;
      int slot;
      int src;
      pick = $urandom_range(0, 19);
      n = searched_count();
      slot = ($urandom_range(0, 9) < 7) ? $urandom_range(0, (n + 3 > 1023) ? 1023 : n + 3)
                                        : $urandom_range(0, MAX_TRIANGLES - 1);
      if (pick < 6) begin
         add_query(rand_coord(), rand_coord(), rand_coord());
      end else if (pick < 12) begin
         add_facet(slot, rand_corner(), rand_corner(), rand_corner());
      end else if (pick < 18) begin
         add_vertex($urandom_range(0, 1) ? int'(rand_corner()) : $urandom_range(0, 1023),
                    rand_coord(), rand_coord(), rand_coord());
      end else if (pick == 18) begin
         queue_request(noise_request(OP_UNUSED));
      end else begin
         // rotated copy of a searched triangle: same centroid, lower index must win
         src = (n > 0) ? $urandom_range(0, n - 1) : 0;
         if (facet_written[src])
            add_facet(slot, facet_plan[src].b, facet_plan[src].c, facet_plan[src].a);
         else
            add_facet(src, rand_corner(), rand_corner(), rand_corner());
      end
   endtask

   task automatic wait_until_idle();
      while (!(accepted_total == queued_total && answers_due.size() == 0))
         @(posedge clock);
      // writes give no response; let the last one retire
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_triangle_count(logic [COUNT_W-1:0] value);
      wait_until_idle();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      model_count = value;
   endtask

   // ---- test sequence ----
   initial begin
      // count at reset value: nothing to find
      add_query(COORD_MAX, COORD_MIN, 0);
      queue_request(noise_request(OP_UNUSED));

      // directed table contents with extreme coordinates and alternating bit patterns
      add_vertex(0, COORD_MAX, COORD_MIN, 0);
      add_vertex(1023, COORD_MIN, COORD_MAX, -1);
      add_vertex(512, 0, 1, COORD_MAX);
      add_vertex(341, 24'sh155555, -24'sh2AAAAA, 24'sh0AAAAA);
      add_vertex(682, -24'sh155556, 24'sh2AAAAA, COORD_MIN);
      add_facet(0, 0, 1023, 512);
      add_facet(1, 1023, 512, 0);    // same centroid as triangle 0
      add_facet(2, 341, 682, 1023);
      add_facet(1023, 682, 341, 0);  // never searched below full count
      add_query(0, 0, 0);

      set_triangle_count(0);
      add_query(COORD_MIN, COORD_MIN, COORD_MIN);

      set_triangle_count(1);
      add_query(COORD_MAX, COORD_MAX, COORD_MAX);

      set_triangle_count(3);
      add_query(COORD_MAX, COORD_MAX, COORD_MAX);
      add_query(COORD_MIN, COORD_MIN, COORD_MIN);
      add_query(0, 0, 0);
      add_query(-24'sd2796203, 24'sd2796202, -24'sd2563186);

      // random phases at small counts, one of them empty
      for (int ph = 0; ph < 10; ph++) begin
         calm_phase = (ph % 4 == 1);
         set_triangle_count((ph == 4) ? '0 : COUNT_W'($urandom_range(1, 16)));
         for (int k = 0; k < 58; k++)
            add_random_item();
      end

      // full table, then counts beyond the table depth
      calm_phase = 1'b1;
      set_triangle_count(COUNT_W'(MAX_TRIANGLES));
      add_query(rand_coord(), rand_coord(), rand_coord());
      add_query(rand_coord(), rand_coord(), rand_coord());
      calm_phase = 1'b0;
      set_triangle_count(COUNT_W'(MAX_TRIANGLES + 1));
      add_query(rand_coord(), rand_coord(), rand_coord());
      set_triangle_count(11'h7FF);
      add_query(rand_coord(), rand_coord(), rand_coord());

      wait_until_idle();
      repeat (16) @(posedge clock);
      if (error_count == 0)
         $display("tb: PASS");
      else
         $display("tb: FAIL");
      $finish;
   end

endmodule
